@@ rtl/core/gwwr_pkg.sv @@
// ----------------------------------------------------------------------------
// gwwr_pkg
// shared constants and types of the greedy word wrap block
// ----------------------------------------------------------------------------
package gwwr_pkg;

  // size of the word buffer and row limits
  localparam int MaxCells = 32;
  localparam int MaxRows  = 16;

  localparam int CellW  = $clog2(MaxCells + 1);  // word / line lengths
  localparam int AddrW  = $clog2(MaxCells);      // word buffer address
  localparam int RowCntW = $clog2(MaxRows + 1);  // rows produced
  localparam int RowW   = $clog2(MaxRows);       // row index

  localparam logic [7:0] SpaceChar = 8'h20;

  // configuration register indexes
  localparam logic RegRowCells = 1'b0;
  localparam logic RegMaxRows  = 1'b1;

  // one result, without the last and done flags
  typedef struct packed {
    logic [7:0]         ch;
    logic [CellW-1:0]   col;
    logic [RowW-1:0]    row;
    logic               row_end;
    logic [RowCntW-1:0] total;
  } res_t;

  // sequencer to output stage
  typedef struct packed {
    logic emit;      // new result into the holding slot
    logic flush;     // item finished: release the held result as the last one
    logic text_end;  // item was the final byte of the text
  } oq_ctl_t;

  // output stage to sequencer
  typedef struct packed {
    logic emit_ok;
    logic push_ok;
    logic pend_valid;
  } oq_st_t;

endpackage

@@ rtl/core/gwwr_out_stage.sv @@
// ----------------------------------------------------------------------------
// gwwr_out_stage
// holding slot plus output register; the last flag is set when a flush releases
// the held result
module gwwr_out_stage import gwwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  oq_ctl_t     ctl_i,
  input  res_t        res_i,
  output oq_st_t      st_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_char, column, row, rows_total, zero pad
  output logic [1:0]  m_axis_tuser,  // row_end, text_done
  output logic        m_axis_tlast
);

  logic pend_valid_q, pend_valid_d;
  res_t pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;
  logic out_last_q, out_last_d;
  logic out_done_q, out_done_d;
  logic push_ok;

  assign push_ok = !out_valid_q || m_axis_tready;

  assign st_o.push_ok    = push_ok;
  assign st_o.emit_ok    = !pend_valid_q || push_ok;
  assign st_o.pend_valid = pend_valid_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_res_d    = out_res_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    if (ctl_i.emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_res_d   = pend_q;
        out_last_d  = 1'b0;
        out_done_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_d       = res_i;
    end else if (ctl_i.flush) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = pend_q;
        out_last_d   = 1'b1;
        out_done_d   = ctl_i.text_end;
        pend_valid_d = 1'b0;
      end else if (ctl_i.text_end) begin
        // final byte gave nothing else: a bare done item
        out_valid_d       = 1'b1;
        out_res_d         = '0;
        out_res_d.total   = res_i.total;
        out_last_d        = 1'b1;
        out_done_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.total, out_res_q.row, out_res_q.col, out_res_q.ch};
  assign m_axis_tuser  = {out_done_q, out_res_q.row_end};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/greedy_word_wrap_rows_top.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_rows_top
// greedy word wrap with hard split of long words, one text byte per transfer
// ----------------------------------------------------------------------------
// one byte at a time through Decide, Store (not for a skipped space), EndChk
// and Fin; placing a word adds Place, each replayed character Read and Emit
// (registered read of the word buffer), each joining space or row close its
// own state; a final byte adds its row closes; sink stalls add on top.
// a result waits in the holding slot until the next one is formed or the byte
// finishes, so the last one of each byte can carry tlast; reset clears state.
// ----------------------------------------------------------------------------
module greedy_word_wrap_rows_top import gwwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [5:0]  cfg_wdata_i,
  // text in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // text_byte
  input  logic        s_axis_tlast,  // end_of_text
  // placed characters and row ends out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_char, column, row, rows_total, zero pad
  output logic [1:0]  m_axis_tuser,  // row_end, text_done
  output logic        m_axis_tlast   // last
);

  // sequencer codes
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDecide = 4'd1;
  localparam logic [3:0] StStore  = 4'd2;
  localparam logic [3:0] StPlace  = 4'd3;
  localparam logic [3:0] StSpace  = 4'd4;
  localparam logic [3:0] StRead   = 4'd5;
  localparam logic [3:0] StEmit   = 4'd6;
  localparam logic [3:0] StClose  = 4'd7;
  localparam logic [3:0] StEndChk = 4'd8;
  localparam logic [3:0] StEClose = 4'd9;
  localparam logic [3:0] StFin    = 4'd10;

  // configuration
  logic [CellW-1:0]   row_cells_q, row_cells_d;
  logic [RowCntW-1:0] max_rows_q, max_rows_d;
  logic [CellW-1:0]   cells_now;
  logic [RowCntW-1:0] lim_now;

  // sequencer and text state
  logic [3:0]         state_q, state_d;
  logic [3:0]         ret_q, ret_d;      // where a word placement returns to
  logic [3:0]         cnext_q, cnext_d;  // after a row close that did not halt
  logic [7:0]         byte_q, byte_d;
  logic               end_q, end_d;
  logic [CellW-1:0]   cells_q, cells_d;
  logic [RowCntW-1:0] lim_q, lim_d;
  logic [CellW-1:0]   wl_q, wl_d;
  logic [CellW-1:0]   line_q, line_d;
  logic [RowCntW-1:0] rows_q, rows_d;
  logic               halted_q, halted_d;
  logic [CellW-1:0]   cnt_q, cnt_d;
  logic [CellW-1:0]   idx_q, idx_d;
  logic               split_q, split_d;

  // word buffer
  logic [7:0] word_mem [MaxCells];
  logic [7:0] rd_data_q;
  logic       wr_en, rd_en;

  // output stage link
  oq_ctl_t ctl;
  oq_st_t  st;
  res_t    res;

  logic [CellW:0]     fit_sum;
  logic [RowCntW-1:0] rows_inc;
  logic               close_halts;
  logic               fin_ok;

  // clamp width and row limit into their legal ranges
  always_comb begin
    cells_now = row_cells_q;
    if (row_cells_q == '0) cells_now = CellW'(1);
    else if (row_cells_q > CellW'(MaxCells)) cells_now = CellW'(MaxCells);
    lim_now = max_rows_q;
    if (max_rows_q == '0) lim_now = RowCntW'(1);
    else if (max_rows_q > RowCntW'(MaxRows)) lim_now = RowCntW'(MaxRows);
  end

  always_comb begin
    row_cells_d = row_cells_q;
    max_rows_d  = max_rows_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegRowCells: row_cells_d = cfg_wdata_i[CellW-1:0];
        RegMaxRows:  max_rows_d  = cfg_wdata_i[RowCntW-1:0];
        default:     ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign fit_sum       = {1'b0, line_q} + {1'b0, wl_q} + (CellW+1)'(1);
  assign rows_inc      = rows_q + RowCntW'(1);
  assign close_halts   = (rows_inc >= lim_q);
  // nothing to release and no done item owed: no need to wait for the sink
  assign fin_ok        = st.push_ok || (!st.pend_valid && !end_q);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cnext_d  = cnext_q;
    byte_d   = byte_q;
    end_d    = end_q;
    cells_d  = cells_q;
    lim_d    = lim_q;
    wl_d     = wl_q;
    line_d   = line_q;
    rows_d   = rows_q;
    halted_d = halted_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    split_d  = split_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    ctl      = '0;
    ctl.text_end = end_q;
    res          = '0;
    res.col      = line_q;
    res.row      = rows_q[RowW-1:0];
    res.total    = rows_q;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          byte_d  = s_axis_tdata;
          end_d   = s_axis_tlast;
          cells_d = cells_now;
          lim_d   = lim_now;
          // limit may have been lowered since the last byte
          if (rows_q >= lim_now) halted_d = 1'b1;
          // width may have been lowered mid-word
          if (wl_q > cells_now) wl_d = cells_now;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (halted_q) begin
          state_d = StEndChk;
        end else if (byte_q == SpaceChar) begin
          if (wl_q != '0) begin
            ret_d   = StEndChk;
            state_d = StPlace;
          end else begin
            state_d = StEndChk;
          end
        end else if (wl_q >= cells_q) begin
          // word too long: flush the open row, then a full-width chunk row
          cnt_d   = cells_q;
          idx_d   = '0;
          wl_d    = '0;
          split_d = 1'b1;
          ret_d   = StStore;
          if (line_q != '0) begin
            cnext_d = StRead;
            state_d = StClose;
          end else begin
            state_d = StRead;
          end
        end else begin
          state_d = StStore;
        end
      end
      StStore: begin
        if (!halted_q) begin
          wr_en = 1'b1;
          wl_d  = wl_q + CellW'(1);
        end
        state_d = StEndChk;
      end
      StPlace: begin
        cnt_d   = wl_q;
        idx_d   = '0;
        wl_d    = '0;
        split_d = 1'b0;
        if (line_q == '0) begin
          state_d = StRead;
        end else if (fit_sum <= {1'b0, cells_q}) begin
          state_d = StSpace;
        end else begin
          cnext_d = StRead;
          state_d = StClose;
        end
      end
      StSpace: begin
        if (st.emit_ok) begin
          ctl.emit = 1'b1;
          res.ch   = SpaceChar;
          line_d   = line_q + CellW'(1);
          state_d  = StRead;
        end
      end
      StRead: begin
        if (idx_q == cnt_q) begin
          if (split_q) begin
            split_d = 1'b0;
            cnext_d = ret_q;
            state_d = StClose;
          end else begin
            state_d = ret_q;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (st.emit_ok) begin
          ctl.emit = 1'b1;
          res.ch   = rd_data_q;
          line_d   = line_q + CellW'(1);
          idx_d    = idx_q + CellW'(1);
          state_d  = StRead;
        end
      end
      StClose: begin
        if (st.emit_ok) begin
          ctl.emit    = 1'b1;
          res.row_end = 1'b1;
          res.total   = rows_inc;
          rows_d      = rows_inc;
          line_d      = '0;
          if (close_halts) begin
            halted_d = 1'b1;
            state_d  = ret_q;
          end else begin
            state_d  = cnext_q;
          end
        end
      end
      StEndChk: begin
        if (!end_q) begin
          state_d = StFin;
        end else if (!halted_q && wl_q != '0) begin
          ret_d   = StEClose;
          state_d = StPlace;
        end else begin
          state_d = StEClose;
        end
      end
      StEClose: begin
        // close the open row, or give one empty row if none was made
        if (!halted_q && (line_q != '0 || rows_q == '0)) begin
          ret_d   = StEClose;
          cnext_d = StEClose;
          state_d = StClose;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_ok) begin
          ctl.flush = 1'b1;
          if (end_q) begin
            wl_d     = '0;
            line_d   = '0;
            rows_d   = '0;
            halted_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_cells_q <= CellW'(MaxCells);
      max_rows_q  <= RowCntW'(MaxRows);
      wl_q        <= '0;
      line_q      <= '0;
      rows_q      <= '0;
      halted_q    <= 1'b0;
      split_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_cells_q <= row_cells_d;
      max_rows_q  <= max_rows_d;
      wl_q        <= wl_d;
      line_q      <= line_d;
      rows_q      <= rows_d;
      halted_q    <= halted_d;
      split_q     <= split_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    cnext_q <= cnext_d;
    byte_q  <= byte_d;
    end_q   <= end_d;
    cells_q <= cells_d;
    lim_q   <= lim_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
  end

  // word buffer: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) word_mem[wl_q[AddrW-1:0]] <= byte_q;
    if (rd_en) rd_data_q <= word_mem[idx_q[AddrW-1:0]];
  end

  gwwr_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .res_i         (res),
    .st_o          (st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> st.emit_ok)
    else $error("result formed with no room in the output stage");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !st.pend_valid)
    else $error("new byte taken while a result is still held back");

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= RowCntW'(MaxRows))
    else $error("row count beyond the row limit");

  a_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q <= CellW'(MaxCells))
    else $error("buffered word longer than the word buffer");

endmodule

@@ tb/greedy_word_wrap_rows_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_rows_top_tb
// self-checking bench for the greedy word wrap block: a directed table of
// text bytes and register writes, then random texts under random flow
// control, every output transfer checked against a behavioural predictor
// ----------------------------------------------------------------------------
module greedy_word_wrap_rows_top_tb;
  import gwwr_pkg::*;

  localparam int SettleCycles = 100;  // worst-case replay of a full word plus margin
  localparam int RandItems    = 300;
  localparam int MaxReports   = 10;
  localparam int NumDir       = 34;

  // one output transfer, all fields unpacked
  typedef struct packed {
    logic [7:0]         ch;
    logic [CellW-1:0]   col;
    logic [RowW-1:0]    row;
    logic               row_end;
    logic               done;
    logic [RowCntW-1:0] total;
    logic               last;
  } wrap_res_t;

  typedef enum logic {ROW_XFER, ROW_CFG} stim_kind_e;

  // directed row: a text byte, or a write of both registers (val = width, lim = row limit)
  typedef struct packed {
    stim_kind_e kind;
    logic [7:0] val;
    logic [5:0] lim;
    logic       eot;
    logic       typed;
    wrap_res_t  exp;
  } stim_row_t;

  localparam wrap_res_t NoRes = '0;
  // empty text after reset: one empty row, closing the text
  localparam wrap_res_t EmptyRow = '{ch: 8'h00, col: 6'd0, row: 4'd0, row_end: 1'b1,
                                     done: 1'b1, total: 5'd1, last: 1'b1};
  // final byte arriving after the row limit: done-only transfer with the count
  localparam wrap_res_t HaltedDone2 = '{ch: 8'h00, col: 6'd0, row: 4'd0, row_end: 1'b0,
                                        done: 1'b1, total: 5'd2, last: 1'b1};

  localparam stim_row_t DirTbl [0:NumDir-1] = '{
    // empty text, and the byte extremes as one-letter texts
    '{ROW_XFER, 8'h20, 6'd0,  1'b1, 1'b1, EmptyRow},
    '{ROW_XFER, 8'h00, 6'd0,  1'b1, 1'b0, NoRes},
    '{ROW_XFER, 8'hFF, 6'd0,  1'b1, 1'b0, NoRes},
    // narrow rows, two-row limit: "ab cd" wraps onto a second row
    '{ROW_CFG,  8'd3,  6'd2,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h61, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h62, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h20, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h63, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h64, 6'd0,  1'b1, 1'b0, NoRes},
    // long word split into full rows until the limit halts the text
    '{ROW_XFER, 8'h61, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h62, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h63, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h64, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h65, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h66, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h67, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h68, 6'd0,  1'b1, 1'b1, HaltedDone2},
    // zero width and zero limit clamp to one
    '{ROW_CFG,  8'd0,  6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h78, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h20, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h79, 6'd0,  1'b1, 1'b0, NoRes},
    // oversized width and limit clamp to the maximum, word left open
    '{ROW_CFG,  8'd63, 6'd31, 1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h70, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h71, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h72, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h73, 6'd0,  1'b0, 1'b0, NoRes},
    // width lowered under the buffered word: truncate, then hard split
    '{ROW_CFG,  8'd2,  6'd31, 1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h51, 6'd0,  1'b0, 1'b0, NoRes},
    // limit lowered below the rows already made: halts at the next byte
    '{ROW_CFG,  8'd2,  6'd1,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h7A, 6'd0,  1'b1, 1'b0, NoRes},
    // runs of spaces around a word, limit written with bit 5 set
    '{ROW_CFG,  8'd32, 6'd48, 1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h20, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h77, 6'd0,  1'b0, 1'b0, NoRes},
    '{ROW_XFER, 8'h20, 6'd0,  1'b1, 1'b0, NoRes}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [5:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  greedy_word_wrap_rows_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // wrap predictor: own copy of the word buffer, counters and registers
  // --------------------------------------------------------------------------
  logic [7:0] wrap_word [MaxCells];
  int         wrap_word_len  = 0;
  int         wrap_line_len  = 0;
  int         wrap_rows_made = 0;
  bit         wrap_halted    = 1'b0;
  int         row_cells_reg  = 32;   // raw register contents, clamped per byte
  int         max_rows_reg   = 16;
  int         row_lim;

  wrap_res_t  byte_res_q [$];        // transfers caused by the current byte
  wrap_res_t  wrap_expect_q [$];     // transfers still to come out of m_axis

  int fail_cnt = 0;
  int n_items  = 0;
  bit src_burst = 1'b0;              // sender without gaps
  bit snk_burst = 1'b0;              // receiver without stalls

  function automatic void emit_res(input logic [7:0] ch, input int col, input int rw,
                                   input bit rend, input int total);
    wrap_res_t r;
    r         = '0;
    r.ch      = ch;
    r.col     = col[CellW-1:0];
    r.row     = rw[RowW-1:0];
    r.row_end = rend;
    r.total   = total[RowCntW-1:0];
    byte_res_q.push_back(r);
  endfunction

  function automatic void close_row();
    emit_res(8'h00, wrap_line_len, wrap_rows_made, 1'b1, wrap_rows_made + 1);
    wrap_rows_made++;
    wrap_line_len = 0;
    if (wrap_rows_made >= row_lim) wrap_halted = 1'b1;
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    emit_res(ch, wrap_line_len, wrap_rows_made, 1'b0, wrap_rows_made);
    wrap_line_len++;
  endfunction

  function automatic void put_word(input int cnt);
    for (int i = 0; i < cnt && i < MaxCells; i++) put_char(wrap_word[i]);
  endfunction

  // finished word joins the row after a space, or opens a new row
  function automatic void place_word(input int cells);
    int wl;
    wl = wrap_word_len;
    wrap_word_len = 0;
    if (wrap_halted) return;
    if (wrap_line_len == 0) begin
      put_word(wl);
    end else if (wrap_line_len + 1 + wl <= cells) begin
      put_char(SpaceChar);
      put_word(wl);
    end else begin
      close_row();
      if (wrap_halted) return;
      put_word(wl);
    end
  endfunction

  // word wider than a row: flush the open row, then one full-width row
  function automatic void hard_split(input int cells);
    wrap_word_len = 0;
    if (wrap_line_len > 0) begin
      close_row();
      if (wrap_halted) return;
    end
    put_word(cells);
    close_row();
  endfunction

  function automatic void wrap_predict(input logic [7:0] txt, input logic eot);
    int cells;
    cells   = (row_cells_reg < 1) ? 1 : (row_cells_reg > MaxCells) ? MaxCells : row_cells_reg;
    row_lim = (max_rows_reg < 1) ? 1 : (max_rows_reg > MaxRows) ? MaxRows : max_rows_reg;
    byte_res_q.delete();
    if (wrap_rows_made >= row_lim) wrap_halted = 1'b1;
    if (wrap_word_len > cells) wrap_word_len = cells;
    if (!wrap_halted) begin
      if (txt == SpaceChar) begin
        if (wrap_word_len > 0) place_word(cells);
      end else begin
        if (wrap_word_len >= cells) hard_split(cells);
        if (!wrap_halted && wrap_word_len < MaxCells) begin
          wrap_word[wrap_word_len] = txt;
          wrap_word_len++;
        end
      end
    end
    if (eot) begin
      if (!wrap_halted && wrap_word_len > 0) place_word(cells);
      if (!wrap_halted && wrap_line_len > 0) close_row();
      if (!wrap_halted && wrap_rows_made == 0) close_row();
      if (byte_res_q.size() == 0) emit_res(8'h00, 0, 0, 1'b0, wrap_rows_made);
      byte_res_q[byte_res_q.size()-1].done = 1'b1;
      wrap_word_len  = 0;
      wrap_line_len  = 0;
      wrap_rows_made = 0;
      wrap_halted    = 1'b0;
    end
    if (byte_res_q.size() > 0) byte_res_q[byte_res_q.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // generous upper bound: every byte with its worst replay and stall, many times over
  initial begin
    #4ms;
    $display("greedy_word_wrap_rows_top_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sender side: all tasks start and return on a falling edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] txt, input logic eot,
                           input logic typed, input wrap_res_t exp);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= txt;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    // transfer taken at this edge
    wrap_predict(txt, eot);
    if (typed) begin
      byte_res_q.delete();
      byte_res_q.push_back(exp);
    end
    foreach (byte_res_q[i]) wrap_expect_q.push_back(byte_res_q[i]);
    n_items++;
    @(negedge clk_i);
  endtask

  // drop tvalid, let every expected transfer arrive, then let any buffering finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (wrap_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // both registers, one per cycle; only called with the block idle
  task automatic set_config(input logic [5:0] cells, input logic [5:0] rows);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegRowCells;
    cfg_wdata_i <= cells;
    @(negedge clk_i);
    cfg_addr_i  <= RegMaxRows;
    cfg_wdata_i <= rows;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    row_cells_reg = int'(cells);
    max_rows_reg  = int'(rows[4:0]);
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stall per transfer, compare with oldest expectation
  // --------------------------------------------------------------------------
  task automatic report_fail(input string what, input wrap_res_t want, input wrap_res_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReports)
      $display({"%0t %s: exp ch %02h col %0d row %0d end %0b done %0b tot %0d last %0b",
                " | got ch %02h col %0d row %0d end %0b done %0b tot %0d last %0b"},
               $realtime, what, want.ch, want.col, want.row, want.row_end, want.done,
               want.total, want.last, got.ch, got.col, got.row, got.row_end, got.done,
               got.total, got.last);
  endtask

  initial begin
    int        stall;
    wrap_res_t got;
    wrap_res_t want;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = snk_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      // tdata: out_char, column, row, rows_total; tuser: row_end, done
      got.ch      = m_axis_tdata[7:0];
      got.col     = m_axis_tdata[13:8];
      got.row     = m_axis_tdata[17:14];
      got.total   = m_axis_tdata[22:18];
      got.row_end = m_axis_tuser[0];
      got.done    = m_axis_tuser[1];
      got.last    = m_axis_tlast;
      if (wrap_expect_q.size() == 0) begin
        report_fail("unexpected transfer", NoRes, got);
      end else begin
        want = wrap_expect_q.pop_front();
        if (got !== want) report_fail("mismatch", want, got);
      end
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         start_items;
    int         eff_cells;
    int         n_words;
    int         wlen;
    int         n_texts;
    bit         close_text;
    logic [7:0] ch;
    logic [7:0] text_q [$];

    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = RegRowCells;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; register rows wait for the block to go quiet first
    for (int i = 0; i < NumDir; i++) begin
      if (DirTbl[i].kind == ROW_CFG) begin
        wait_idle();
        set_config(DirTbl[i].val[5:0], DirTbl[i].lim);
      end else begin
        send_byte(DirTbl[i].val, DirTbl[i].eot, DirTbl[i].typed, DirTbl[i].exp);
      end
    end

    // random phases: new registers, then a few texts, mostly well-formed words
    start_items = n_items;
    while (n_items - start_items < RandItems) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       ch = 8'd0;
        1:       ch = 8'd1;
        2:       ch = 8'($urandom_range(2, 6));
        3:       ch = 8'd32;
        4:       ch = 8'($urandom_range(33, 63));
        default: ch = 8'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 5))
        0:       set_config(ch[5:0], 6'd0);
        1:       set_config(ch[5:0], 6'd1);
        2:       set_config(ch[5:0], 6'($urandom_range(2, 5)));
        3:       set_config(ch[5:0], 6'd16);
        4:       set_config(ch[5:0], 6'($urandom_range(17, 63)));
        default: set_config(ch[5:0], 6'($urandom_range(0, 63)));
      endcase
      eff_cells = (row_cells_reg < 1) ? 1 : (row_cells_reg > MaxCells) ? MaxCells
                                                                        : row_cells_reg;
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      n_texts   = $urandom_range(1, 4);
      for (int t = 0; t < n_texts; t++) begin
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary bytes, heavy on spaces
          repeat ($urandom_range(1, 12))
            text_q.push_back(($urandom_range(0, 2) == 0) ? SpaceChar
                                                           : 8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 3) == 0) text_q.push_back(SpaceChar);
          n_words = $urandom_range(1, 8);
          for (int w = 0; w < n_words; w++) begin
            if (w > 0) repeat ($urandom_range(1, 3)) text_q.push_back(SpaceChar);
            // mostly short words, now and then one long enough to split
            if ($urandom_range(0, 7) == 0)
              wlen = $urandom_range(eff_cells, (2 * eff_cells + 1 > 40) ? 40
                                                                         : 2 * eff_cells + 1);
            else
              wlen = $urandom_range(1, (eff_cells < 8) ? eff_cells + 1 : 8);
            repeat (wlen) begin
              if ($urandom_range(0, 7) == 0) begin
                do ch = 8'($urandom_range(0, 255)); while (ch == SpaceChar);
              end else begin
                ch = 8'($urandom_range(8'h21, 8'h7E));
              end
              text_q.push_back(ch);
            end
          end
          if ($urandom_range(0, 3) == 0) text_q.push_back(SpaceChar);
        end
        // now and then the phase ends mid-text, so new registers hit an open text
        close_text = !(t == n_texts - 1 && $urandom_range(0, 4) == 0);
        foreach (text_q[i])
          send_byte(text_q[i], close_text && (i == text_q.size() - 1), 1'b0, NoRes);
        // now and then the sender holds off until everything has drained
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
    end

    // drain, then a quiet stretch to catch stray transfers
    s_axis_tvalid <= 1'b0;
    while (wrap_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("greedy_word_wrap_rows_top_tb OK");
    end else begin
      $display("greedy_word_wrap_rows_top_tb NOT OK");
    end
    $finish;
  end

endmodule
